// File: hdl/aesm_pkg.sv
// ----------------------------------------------------------------------------
// aesm_pkg: shared types, codes and byte functions
// Holds the S-box tables, register and mode codes and round helpers.
// ----------------------------------------------------------------------------
package aesm_pkg;

   // 16-byte block, byte 0 in the most significant position
   typedef logic [0:15][7:0] blk_type;

   // control handed to the round unit
   typedef struct packed {
      logic dec;       // inverse cipher round
      logic add_only;  // initial key addition only
      logic skip_mix;  // final round without (inverse) mix columns
   } round_ctl_type;

   // register indexes
   localparam logic [2:0] REG_KEY0     = 3'd0;
   localparam logic [2:0] REG_KEY1     = 3'd1;
   localparam logic [2:0] REG_KEY2     = 3'd2;
   localparam logic [2:0] REG_KEY3     = 3'd3;
   localparam logic [2:0] REG_KEY_SIZE = 3'd4;
   localparam logic [2:0] REG_MODE     = 3'd5;
   localparam logic [2:0] REG_IV_HIGH  = 3'd6;
   localparam logic [2:0] REG_IV_LOW   = 3'd7;

   // key sizes
   localparam logic [1:0] KSIZE_128 = 2'd0;
   localparam logic [1:0] KSIZE_192 = 2'd1;
   localparam logic [1:0] KSIZE_256 = 2'd2;

   // chaining modes
   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_CFB = 2'd2;
   localparam logic [1:0] MODE_OFB = 2'd3;

   localparam logic [0:255][7:0] SBOX_FWD = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [0:255][7:0] SBOX_INV = {
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // multiply by x in the field, reduction polynomial 0x1b
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
   endfunction

   // number of rounds; the unused size code runs as 128 bit
   function automatic logic [3:0] rounds_of(input logic [1:0] ks);
      case (ks)
         KSIZE_192: return 4'd12;
         KSIZE_256: return 4'd14;
         default:   return 4'd10;
      endcase
   endfunction

   // key length in words
   function automatic logic [3:0] key_words_of(input logic [1:0] ks);
      case (ks)
         KSIZE_192: return 4'd6;
         KSIZE_256: return 4'd8;
         default:   return 4'd4;
      endcase
   endfunction

endpackage

// File: hdl/aesm_if.sv
// ----------------------------------------------------------------------------
// aesm channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aesm_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        first_block;
   logic [63:0] block_high;
   logic [63:0] block_low;

   modport source (output valid, kind, first_block, block_high, block_low, input ready);
   modport sink   (input valid, kind, first_block, block_high, block_low, output ready);
endinterface

interface aesm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;

   modport source (output valid, out_high, out_low, input ready);
   modport sink   (input valid, out_high, out_low, output ready);
endinterface

// File: hdl/aesm_round.sv
// ----------------------------------------------------------------------------
// aesm_round: one cipher round
// Forward or inverse AES round, or the initial key addition, on a block.
// ----------------------------------------------------------------------------
module aesm_round (
   input  aesm_pkg::blk_type       state_in,
   input  aesm_pkg::blk_type       round_key,
   input  aesm_pkg::round_ctl_type ctl,
   output aesm_pkg::blk_type       state_out
);
   import aesm_pkg::*;

   blk_type sub_f, shf_f, mix_f, enc_out;
   blk_type shf_i, sub_i, add_i, mix_i, dec_out;

   // forward path: sub bytes, shift rows, mix columns, add key
   always_comb begin
      logic [7:0] a0, a1, a2, a3, all;
      for (int i = 0; i < 16; i++) begin
         sub_f[i] = SBOX_FWD[state_in[i]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shf_f[4*c + r] = sub_f[4*((c + r) % 4) + r];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = shf_f[4*c];
         a1 = shf_f[4*c + 1];
         a2 = shf_f[4*c + 2];
         a3 = shf_f[4*c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         mix_f[4*c]     = a0 ^ all ^ xtime(a0 ^ a1);
         mix_f[4*c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
         mix_f[4*c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
         mix_f[4*c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      enc_out = (ctl.skip_mix ? shf_f : mix_f) ^ round_key;
   end

   // inverse path: inverse shift, inverse sub, add key, inverse mix
   always_comb begin
      logic [0:3][7:0] x2, x4, x8, m9, m11, m13, m14;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shf_i[4*((c + r) % 4) + r] = state_in[4*c + r];
         end
      end
      for (int i = 0; i < 16; i++) begin
         sub_i[i] = SBOX_INV[shf_i[i]];
      end
      add_i = sub_i ^ round_key;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            x2[k]  = xtime(add_i[4*c + k]);
            x4[k]  = xtime(x2[k]);
            x8[k]  = xtime(x4[k]);
            m9[k]  = x8[k] ^ add_i[4*c + k];
            m11[k] = x8[k] ^ x2[k] ^ add_i[4*c + k];
            m13[k] = x8[k] ^ x4[k] ^ add_i[4*c + k];
            m14[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         mix_i[4*c]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
         mix_i[4*c + 1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
         mix_i[4*c + 2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
         mix_i[4*c + 3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      end
      dec_out = ctl.skip_mix ? add_i : mix_i;
   end

   // select initial key addition or a full round
   always_comb begin
      if (ctl.add_only) begin
         state_out = state_in ^ round_key;
      end else if (ctl.dec) begin
         state_out = dec_out;
      end else begin
         state_out = enc_out;
      end
   end

endmodule

// File: hdl/aes_block_cipher_modes_top.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_top: AES-128/192/256 with ECB, CBC, CFB and OFB
// Round keys live in a synchronous store; one round runs per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Registers are written through csr_we/csr_index/csr_wdata while the block
//   is idle. A write to a key word or the key size starts a key expansion of
//   44, 52 or 60 key words (one key word per cycle, stored a row of four at a time);
//   no request is taken until it is done. After reset one expansion of the
//   all-zero 128 bit key runs first.
//   Each request on req_if carries one 128 bit block, its direction and the
//   first-block flag that reloads the chaining value from the IV registers.
//   One response on rsp_if follows for every request.
//   At the accepting edge the block enters the round state and the first
//   key-store read is done; the initial key addition and then one round per
//   cycle follow, the last one loading the response register. One request is
//   in flight at a time; the next is taken only after the response handshake.
//   While the receiver stalls the response register holds and req_if.ready
//   stays low. Reset clears the registers and the chaining value to zero.
// ----------------------------------------------------------------------------
module aes_block_cipher_modes_top (
   input  logic             clock,
   input  logic             reset,
   aesm_req_if.sink         req_if,
   aesm_rsp_if.source       rsp_if,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import aesm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_RUN, ST_OUT} state_type;

   state_type     state_ff;
   logic [63:0]   key_ff [4];
   logic [1:0]    ksize_ff, mode_ff;
   logic [63:0]   iv_hi_ff, iv_lo_ff;
   logic          dirty_ff;

   // key expansion
   logic [5:0]       ki_ff;
   logic [2:0]       phase_ff;
   logic [7:0]       rc_ff;
   logic [0:7][31:0] win_ff;

   // cipher datapath
   logic [3:0]    step_ff;
   logic          dec_ff;
   logic          kind_ff;
   blk_type       blk_ff, st_ff, rk_q_ff, res_ff;
   logic [127:0]  chain_ff;
   logic [127:0]  rk_mem [16];

   logic [3:0]    nr, nk;
   logic [5:0]    ki_last;
   logic          key_write, req_fire, core_dec_in;
   logic [31:0]   key_word, t_word, w_new, w_back;
   logic [3:0]    raddr, nxt_step;
   logic [127:0]  chain_sel;
   blk_type       core_in, rnd_out, res_c;
   logic [127:0]  chain_upd;
   round_ctl_type ctl;

   assign nr        = rounds_of(ksize_ff);
   assign nk        = key_words_of(ksize_ff);
   assign ki_last   = {nr, 2'b11};
   assign key_write = csr_we && (csr_index == REG_KEY0 || csr_index == REG_KEY1 ||
                      csr_index == REG_KEY2 || csr_index == REG_KEY3 ||
                      csr_index == REG_KEY_SIZE);
   assign req_if.ready = (state_ff == ST_IDLE) && !dirty_ff;
   assign req_fire  = req_if.valid && req_if.ready;

   // next expanded key word
   always_comb begin
      key_word = ki_ff[0] ? key_ff[ki_ff[2:1]][31:0] : key_ff[ki_ff[2:1]][63:32];
      case (ksize_ff)
         KSIZE_192: w_back = win_ff[5];
         KSIZE_256: w_back = win_ff[7];
         default:   w_back = win_ff[3];
      endcase
      t_word = win_ff[0];
      if (phase_ff == 3'd0) begin
         t_word = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rc_ff, 24'h0};
      end else if (nk == 4'd8 && phase_ff == 3'd4) begin
         t_word = sub_word(win_ff[0]);
      end
      w_new = ({2'b00, ki_ff} < {4'b0000, nk}) ? key_word : (w_back ^ t_word);
   end

   // cipher input and key-store read address
   always_comb begin
      chain_sel   = req_if.first_block ? {iv_hi_ff, iv_lo_ff} : chain_ff;
      core_dec_in = req_if.kind && (mode_ff == MODE_ECB || mode_ff == MODE_CBC);
      case (mode_ff)
         MODE_ECB: core_in = {req_if.block_high, req_if.block_low};
         MODE_CBC: core_in = req_if.kind ? {req_if.block_high, req_if.block_low}
                                         : ({req_if.block_high, req_if.block_low} ^ chain_sel);
         default:  core_in = chain_sel;
      endcase
      nxt_step = step_ff + 4'd1;
      if (state_ff == ST_RUN) begin
         raddr = dec_ff ? (nr - nxt_step) : nxt_step;
      end else begin
         raddr = core_dec_in ? nr : 4'd0;
      end
   end

   // round unit
   assign ctl.dec      = dec_ff;
   assign ctl.add_only = (step_ff == 4'd0);
   assign ctl.skip_mix = (step_ff == nr);

   aesm_round u_round (
      .state_in  (st_ff),
      .round_key (rk_q_ff),
      .ctl       (ctl),
      .state_out (rnd_out)
   );

   // chaining on the finished block
   always_comb begin
      case (mode_ff)
         MODE_ECB: begin
            res_c     = rnd_out;
            chain_upd = chain_ff;
         end
         MODE_CBC: begin
            res_c     = dec_ff ? (rnd_out ^ chain_ff) : rnd_out;
            chain_upd = dec_ff ? blk_ff : rnd_out;
         end
         MODE_CFB: begin
            res_c     = blk_ff ^ rnd_out;
            chain_upd = kind_ff ? blk_ff : (blk_ff ^ rnd_out);
         end
         default: begin
            res_c     = blk_ff ^ rnd_out;
            chain_upd = rnd_out;
         end
      endcase
   end

   // round-key store: row write during expansion, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND && ki_ff[1:0] == 2'b11) begin
         rk_mem[ki_ff[5:2]] <= {win_ff[2], win_ff[1], win_ff[0], w_new};
      end
      rk_q_ff <= rk_mem[raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXPAND) begin
         win_ff <= {w_new, win_ff[0:6]};
      end
      if (req_fire) begin
         blk_ff  <= {req_if.block_high, req_if.block_low};
         st_ff   <= core_in;
         dec_ff  <= core_dec_in;
         kind_ff <= req_if.kind;
      end else if (state_ff == ST_RUN) begin
         st_ff <= rnd_out;
         if (step_ff == nr) begin
            res_ff <= res_c;
         end
      end
   end

   // control, configuration and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         ksize_ff <= '0;
         mode_ff  <= '0;
         iv_hi_ff <= '0;
         iv_lo_ff <= '0;
         dirty_ff <= 1'b1;
         chain_ff <= '0;
         ki_ff    <= '0;
         phase_ff <= '0;
         rc_ff    <= 8'h01;
         step_ff  <= '0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               REG_KEY0:     key_ff[0] <= csr_wdata;
               REG_KEY1:     key_ff[1] <= csr_wdata;
               REG_KEY2:     key_ff[2] <= csr_wdata;
               REG_KEY3:     key_ff[3] <= csr_wdata;
               REG_KEY_SIZE: ksize_ff  <= csr_wdata[1:0];
               REG_MODE:     mode_ff   <= csr_wdata[1:0];
               REG_IV_HIGH:  iv_hi_ff  <= csr_wdata;
               REG_IV_LOW:   iv_lo_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (key_write) begin
            dirty_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (dirty_ff && !key_write) begin
                  state_ff <= ST_EXPAND;
                  ki_ff    <= '0;
                  phase_ff <= '0;
                  rc_ff    <= 8'h01;
               end else if (req_fire) begin
                  state_ff <= ST_RUN;
                  step_ff  <= '0;
                  if (req_if.first_block) begin
                     chain_ff <= {iv_hi_ff, iv_lo_ff};
                  end
               end
            end
            ST_EXPAND: begin
               if (key_write) begin
                  state_ff <= ST_IDLE;
               end else begin
                  ki_ff    <= ki_ff + 6'd1;
                  phase_ff <= ({1'b0, phase_ff} == nk - 4'd1) ? 3'd0 : phase_ff + 3'd1;
                  if (phase_ff == 3'd0 && {2'b00, ki_ff} >= {4'b0000, nk}) begin
                     rc_ff <= xtime(rc_ff);
                  end
                  if (ki_ff == ki_last) begin
                     state_ff <= ST_IDLE;
                     dirty_ff <= 1'b0;
                  end
               end
            end
            ST_RUN: begin
               step_ff <= nxt_step;
               if (step_ff == nr) begin
                  chain_ff <= chain_upd;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_if.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid    = (state_ff == ST_OUT);
   assign rsp_if.out_high = res_ff[0:7];
   assign rsp_if.out_low  = res_ff[8:15];

`ifndef NO_ASSERTIONS
   // one block in flight: no new request while a response waits
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request taken while response pending");

   // requests only run on a fully expanded key schedule
   a_keys_ready: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !dirty_ff && state_ff == ST_IDLE)
      else $error("request accepted with stale round keys");

   // a response never appears the cycle after acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !rsp_if.valid)
      else $error("response too early");
`endif

endmodule

// File: tb/aes_block_cipher_modes_checker.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_checker: cipher predictor and response scoreboard
// Tracks register writes, works out each response block from every
// accepted request and compares accepted responses in order.
// ----------------------------------------------------------------------------
module aes_block_cipher_modes_checker
   import aesm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   aesm_req_if         req_mon,
   aesm_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          blocks_pending
);

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_out_type;

   // shadow registers and chaining state
   logic [63:0] key_reg [4];
   logic [1:0]  size_reg;
   logic [1:0]  mode_reg;
   logic [63:0] iv_hi_reg;
   logic [63:0] iv_lo_reg;
   logic [127:0] chain_reg;
   logic [31:0] sched [60];

   cipher_out_type expected_blocks [$];

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
   endfunction

   function automatic int round_count();
      return size_reg == KSIZE_192 ? 12 : size_reg == KSIZE_256 ? 14 : 10;
   endfunction

   // key schedule from the shadow key words
   function automatic void build_schedule();
      int nk;
      int total;
      logic [31:0] t;
      logic [7:0] rc;
      nk = size_reg == KSIZE_192 ? 6 : size_reg == KSIZE_256 ? 8 : 4;
      total = 4 * (round_count() + 1);
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            rc = 8'h01;
            for (int j = 1; j < i / nk; j++) rc = gf_double(rc);
            t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
         end else if (nk == 8 && i % nk == 4) begin
            t = sbox_word(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
   endfunction

   function automatic blk_type add_round_key(input blk_type s, input int r);
      for (int i = 0; i < 16; i++)
         s[i] ^= sched[r * 4 + i / 4][31 - 8 * (i % 4) -: 8];
      return s;
   endfunction

   function automatic blk_type mix(input blk_type s, input bit inverse);
      blk_type t;
      logic [7:0] a [4];
      t = s;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
         for (int k = 0; k < 4; k++) begin
            if (inverse)
               t[4 * c + k] = gf_mul(a[k], 8'h0e) ^ gf_mul(a[(k + 1) % 4], 8'h0b) ^
                              gf_mul(a[(k + 2) % 4], 8'h0d) ^ gf_mul(a[(k + 3) % 4], 8'h09);
            else
               t[4 * c + k] = gf_mul(a[k], 8'h02) ^ gf_mul(a[(k + 1) % 4], 8'h03) ^
                              a[(k + 2) % 4] ^ a[(k + 3) % 4];
         end
      end
      return t;
   endfunction

   function automatic blk_type forward_cipher(input blk_type s);
      blk_type t;
      int nr;
      nr = round_count();
      s = add_round_key(s, 0);
      for (int r = 1; r <= nr; r++) begin
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
               t[4 * c + k] = SBOX_FWD[s[4 * ((c + k) % 4) + k]];
         if (r != nr) t = mix(t, 1'b0);
         s = add_round_key(t, r);
      end
      return s;
   endfunction

   function automatic blk_type inverse_cipher(input blk_type s);
      blk_type t;
      int nr;
      nr = round_count();
      s = add_round_key(s, nr);
      for (int r = nr - 1; r >= 0; r--) begin
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
               t[4 * ((c + k) % 4) + k] = SBOX_INV[s[4 * c + k]];
         s = add_round_key(t, r);
         if (r != 0) s = mix(s, 1'b1);
      end
      return s;
   endfunction

   // one block through the selected chaining mode
   function automatic cipher_out_type chain_block(input logic decrypt, input logic first,
                                                  input logic [127:0] din);
      blk_type ks;
      logic [127:0] res;
      if (first) chain_reg = {iv_hi_reg, iv_lo_reg};
      build_schedule();
      case (mode_reg)
         MODE_ECB: res = decrypt ? inverse_cipher(din) : forward_cipher(din);
         MODE_CBC: begin
            if (decrypt) begin
               res = inverse_cipher(din) ^ chain_reg;
               chain_reg = din;
            end else begin
               res = forward_cipher(din ^ chain_reg);
               chain_reg = res;
            end
         end
         MODE_CFB: begin
            ks = forward_cipher(chain_reg);
            res = din ^ ks;
            chain_reg = decrypt ? din : res;
         end
         default: begin
            ks = forward_cipher(chain_reg);
            res = din ^ ks;
            chain_reg = ks;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_out_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         size_reg = KSIZE_128;
         mode_reg = MODE_ECB;
         iv_hi_reg = '0;
         iv_lo_reg = '0;
         chain_reg = '0;
         expected_blocks.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[csr_index[1:0]] = csr_wdata;
               REG_KEY_SIZE: size_reg = csr_wdata[1:0];
               REG_MODE:     mode_reg = csr_wdata[1:0];
               REG_IV_HIGH:  iv_hi_reg = csr_wdata;
               REG_IV_LOW:   iv_lo_reg = csr_wdata;
               default: ;
            endcase
         end
         // accepted request
         if (req_mon.valid && req_mon.ready)
            expected_blocks.push_back(chain_block(req_mon.kind, req_mon.first_block,
                                                  {req_mon.block_high, req_mon.block_low}));
         // accepted response
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_blocks.size() == 0) begin
               $error("response with no request outstanding: %h %h",
                      rsp_mon.out_high, rsp_mon.out_low);
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_mon.out_high !== want.hi) begin
                  $error("out_high expected %h actual %h", want.hi, rsp_mon.out_high);
                  fail_count++;
               end
               if (rsp_mon.out_low !== want.lo) begin
                  $error("out_low expected %h actual %h", want.lo, rsp_mon.out_low);
                  fail_count++;
               end
            end
         end
      end
      blocks_pending = expected_blocks.size();
   end

endmodule

// File: tb/aes_block_cipher_modes_top_tb.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_top_tb: stimulus and verdict for the AES mode block
// Directed blocks over every mode and key size, then randomly keyed
// messages with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module aes_block_cipher_modes_top_tb;
   import aesm_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   int          fail_count;
   int          blocks_pending;
   int          burst_left;
   int          sent;
   logic [63:0] cfg [8];

   aesm_req_if req_if ();
   aesm_rsp_if rsp_if ();

   aes_block_cipher_modes_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aes_block_cipher_modes_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .blocks_pending (blocks_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls in changing styles
   int stall_style = 0;
   int stall_left = 0;
   int style_left = 0;
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 2);
         style_left = $urandom_range(50, 400);
      end
      style_left--;
      case (stall_style)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
               rsp_if.ready <= 1'b1;
            end
         end
      endcase
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_regs();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= cfg[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // wait for all responses and for any trailing work
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // one request, sent in bursts with random gaps
   task automatic send_request(input logic dec, input logic first,
                               input logic [63:0] hi, input logic [63:0] lo);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= dec;
      req_if.first_block <= first;
      req_if.block_high <= hi;
      req_if.block_low <= lo;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      sent++;
   endtask

   initial begin
      int n;
      logic dec;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_KEY0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = 1'b0;
      req_if.first_block = 1'b0;
      req_if.block_high = '0;
      req_if.block_low = '0;
      burst_left = 0;
      sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (80) @(posedge clock);

      // chaining value still zero after reset, no first-block flag
      write_reg(REG_MODE, {62'h0, MODE_OFB});
      send_request(1'b0, 1'b0, '0, '0);
      send_request(1'b1, 1'b0, '1, '1);
      drain();

      // every mode, with key size following the mode (size code 3 included)
      for (int m = 0; m < 4; m++) begin
         cfg[0] = '1; cfg[1] = '1; cfg[2] = '1; cfg[3] = '1;
         cfg[4] = {62'h3fff_ffff_ffff_fff0, m[1:0]};
         cfg[5] = {62'h0, m[1:0]};
         cfg[6] = '1; cfg[7] = 64'h0123_4567_89ab_cdef;
         write_all_regs();
         send_request(1'b0, 1'b1, '0, '1);
         send_request(1'b0, 1'b0, '1, '0);
         send_request(1'b1, 1'b1, '1, '1);
         send_request(1'b1, 1'b0, '0, '0);
         drain();
      end

      // random keys and messages
      while (sent < 520) begin
         for (int i = 0; i < 8; i++) cfg[i] = pick_word();
         cfg[4] = {$urandom, $urandom};
         cfg[5] = {$urandom, $urandom};
         write_all_regs();
         n = $urandom_range(20, 60);
         dec = 1'($urandom_range(0, 1));
         for (int i = 0; i < n; i++) begin
            if (i != 0 && $urandom_range(0, 9) == 0) dec = 1'($urandom_range(0, 1));
            send_request(($urandom_range(0, 9) == 0) ? ~dec : dec,
                         i == 0 || $urandom_range(0, 11) == 0, pick_word(), pick_word());
         end
         drain();
      end

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
